FILE: hw/rtl/ama_pkg.sv
// Shared constants and types for the adaptive moving average filter.
package ama_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned TAPS       = 5;
    localparam int unsigned JUMP_RECIP = 5;

    localparam int unsigned TAP_W  = $clog2(TAPS);
    localparam int unsigned HIST_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int unsigned SUM_W  = DATA_W + TAP_W;
    localparam int unsigned THR_W  = DATA_W + 1 + $clog2(JUMP_RECIP);

    // The sum is divided in two halves; each partial dividend is DIV_W bits wide.
    localparam int unsigned LO_W   = DATA_W / 2;
    localparam int unsigned DIV_W  = LO_W + TAP_W;
    localparam int unsigned DIV_SH = DIV_W + TAP_W;
    localparam int unsigned PROD_W = 2 * DIV_W + 1;

    // Rounded-up reciprocal; exact for every DIV_W-bit dividend.
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SH) + 64'(TAPS) - 64'd1) / 64'(TAPS);

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [SUM_W-1:0]  t_sum;

    typedef struct packed {
        logic vld;
        logic jmp;
    } t_ctl;

endpackage

FILE: hw/rtl/ama_div.sv
// Three-stage pipelined division of the history sum by the tap count.
module ama_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ama_pkg::t_ctl         i_ctl,
    input  ama_pkg::t_sum         i_sum,
    output ama_pkg::t_ctl         o_ctl,
    output ama_pkg::t_data        o_quot
);

    ama_pkg::t_ctl                   r_ctl2;
    ama_pkg::t_ctl                   r_ctl3;
    ama_pkg::t_ctl                   r_ctl4;

    logic [ama_pkg::DIV_W-1:0]       r_hi2;
    logic [ama_pkg::LO_W-1:0]        r_lo2;
    logic [ama_pkg::LO_W-1:0]        r_q1_2;
    logic [ama_pkg::DIV_W-1:0]       r_v3;
    logic [ama_pkg::LO_W-1:0]        r_q1_3;
    ama_pkg::t_data                  r_quot;

    logic [ama_pkg::PROD_W-1:0]      w_prod1;
    logic [ama_pkg::PROD_W-1:0]      w_prod2;
    logic [ama_pkg::DIV_W-1:0]       w_hi;
    logic [ama_pkg::DIV_W-1:0]       w_rem;
    logic [ama_pkg::LO_W-1:0]        n_q1;
    logic [ama_pkg::LO_W-1:0]        n_q2;

    // Upper half first: its quotient is below 2^LO_W because the mean fits DATA_W bits.
    assign w_hi    = i_sum[ama_pkg::SUM_W-1 -: ama_pkg::DIV_W];
    assign w_prod1 = ama_pkg::PROD_W'(w_hi) * ama_pkg::PROD_W'(ama_pkg::RECIP);
    assign n_q1    = ama_pkg::LO_W'(w_prod1 >> ama_pkg::DIV_SH);

    // The remainder of the upper half is below TAPS and heads the lower dividend.
    assign w_rem   = r_hi2 - ama_pkg::DIV_W'(ama_pkg::DIV_W'(r_q1_2) *
                                            ama_pkg::DIV_W'(ama_pkg::TAPS));

    assign w_prod2 = ama_pkg::PROD_W'(r_v3) * ama_pkg::PROD_W'(ama_pkg::RECIP);
    assign n_q2    = ama_pkg::LO_W'(w_prod2 >> ama_pkg::DIV_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi2  <= w_hi;
            r_lo2  <= i_sum[ama_pkg::LO_W-1:0];
            r_q1_2 <= n_q1;
            if (ama_pkg::TAP_W > 0) begin
                r_v3 <= ama_pkg::DIV_W'({w_rem, r_lo2});
            end else begin
                r_v3 <= ama_pkg::DIV_W'(r_lo2);
            end
            r_q1_3 <= r_q1_2;
            r_quot <= {r_q1_3, n_q2};
        end
    end

    assign o_ctl  = r_ctl4;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/adaptive_moving_average.sv
// Top level of the adaptive moving average filter with jump reload.
// Stages: a sample's result is shown once it has passed one history stage and three
// division stages, and it can transfer while it is shown.
// Throughput: one sample per cycle; the whole pipeline halts while a result waits.
// Reset: history and running sum clear to zero, the pipeline empties, and the
// input is ready once the run flag has been registered after reset is released.
module adaptive_moving_average (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ama_pkg::t_data        i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ama_pkg::t_data        o_smoothed,
    output logic                  o_jumped
);

    ama_pkg::t_data                  r_hist [ama_pkg::TAPS];
    ama_pkg::t_data                  n_hist [ama_pkg::TAPS];
    ama_pkg::t_sum                   r_sum;
    ama_pkg::t_sum                   n_sum;
    ama_pkg::t_ctl                   r_ctl1;
    ama_pkg::t_ctl                   w_ctl_out;
    logic                            r_run;

    logic                            w_en;
    logic                            w_acc;
    ama_pkg::t_data                  w_diff;
    logic [ama_pkg::THR_W-1:0]       w_lhs;
    logic [ama_pkg::THR_W-1:0]       w_rhs;
    logic                            w_jump;

    assign w_en       = !w_ctl_out.vld || i_out_ready;
    assign o_in_ready = r_run && w_en;
    assign w_acc      = i_in_valid && o_in_ready;

    // Jump when 5 * (|x - newest| + 1) exceeds newest + 1.
    assign w_diff = (i_sample >= r_hist[0]) ? (i_sample - r_hist[0]) : (r_hist[0] - i_sample);
    assign w_lhs  = (ama_pkg::THR_W'(w_diff) + ama_pkg::THR_W'(1)) *
                    ama_pkg::THR_W'(ama_pkg::JUMP_RECIP);
    assign w_rhs  = ama_pkg::THR_W'(r_hist[0]) + ama_pkg::THR_W'(1);
    assign w_jump = w_lhs > w_rhs;

    always_comb begin
        if (w_jump) begin
            for (int i = 0; i < ama_pkg::TAPS; i++) begin
                n_hist[i] = i_sample;
            end
            n_sum = ama_pkg::SUM_W'(i_sample) * ama_pkg::SUM_W'(ama_pkg::TAPS);
        end else begin
            n_hist[0] = i_sample;
            for (int i = 1; i < ama_pkg::TAPS; i++) begin
                n_hist[i] = r_hist[i-1];
            end
            n_sum = r_sum + ama_pkg::SUM_W'(i_sample)
                  - ama_pkg::SUM_W'(r_hist[ama_pkg::HIST_W'(ama_pkg::TAPS - 1)]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ama_pkg::TAPS; i++) begin
                r_hist[i] <= '0;
            end
            r_sum  <= '0;
            r_ctl1 <= '0;
            r_run  <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (w_acc) begin
                r_hist <= n_hist;
                r_sum  <= n_sum;
            end
            if (w_en) begin
                r_ctl1.vld <= w_acc;
                r_ctl1.jmp <= w_jump;
            end
        end
    end

    // A jump loads TAPS copies of the sample, so the mean is the sample itself.
    ama_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_ctl1),
        .i_sum   (r_sum),
        .o_ctl   (w_ctl_out),
        .o_quot  (o_smoothed)
    );

    assign o_out_valid = w_ctl_out.vld;
    assign o_jumped    = w_ctl_out.jmp;

endmodule

FILE: hw/rtl/ama_chk.sv
// Port-level checker for the adaptive moving average filter, bound to the top level.
module ama_chk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  ama_pkg::t_data        i_sample,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  ama_pkg::t_data        o_smoothed,
    input  logic                  o_jumped
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_smoothed) && $stable(o_jumped))
        else $error("result changed while stalled");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With no result pending, the input is never held off once out of reset.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(i_rst_n) |-> o_in_ready)
        else $error("input held off with empty output");

    // A transfer that flows through the pipeline unstalled appears as a valid result, and a jump
    // passes the sample through unchanged.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 o_in_ready ##1 o_in_ready ##1 o_in_ready |=>
            o_out_valid && (!o_jumped || o_smoothed == $past(i_sample, 4)))
        else $error("jump result does not match its sample");

endmodule

bind adaptive_moving_average ama_chk u_ama_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_sample    (i_sample),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_smoothed  (o_smoothed),
    .o_jumped    (o_jumped)
);
